[hdl/ffha_pkg.sv]
`default_nettype none
package ffha_pkg;

  // default table depth and page size
  localparam int HOLE_SLOTS_DEF = 2048;
  localparam int PAGE_BYTES_DEF = 4096;

  // alignment values fit in this many bits (up to 16 KiB)
  localparam int ALIGN_W = 15;
  localparam logic [ALIGN_W-1:0] BIG_ALIGN = 15'h4000;

  // request kinds
  localparam logic [1:0] KIND_BYTES = 2'd0;
  localparam logic [1:0] KIND_PAGES = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;
  localparam logic [1:0] KIND_INIT  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // configuration register indexes
  localparam logic CFG_POOL_BASE = 1'b0;
  localparam logic CFG_POOL_LEN  = 1'b1;

endpackage
`default_nettype wire

[hdl/ffha_ram.sv]
`default_nettype none
module ffha_ram #(
  parameter int DEPTH = ffha_pkg::HOLE_SLOTS_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 76
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hdl/ffha_rem.sv]
`default_nettype none
module ffha_rem (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [ffha_pkg::ALIGN_W-1:0]   value,
  input  wire logic [ffha_pkg::ALIGN_W-1:0]   divisor,
  output logic                                done,
  output logic      [ffha_pkg::ALIGN_W-1:0]   rem
);

  // alignments are powers of two, so the remainder is the masked low bits
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      rem  <= '0;
    end else begin
      done <= start;
      if (start) begin
        rem <= value & (divisor - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

[hdl/first_fit_hole_allocator.sv]
// channel   signals                                           direction
// in        in_valid/in_ready, kind, amount, block_base,       to block
//           align_16k
// out       out_valid/out_ready, address, status, free_bytes   from block
// cfg       cfg_we, cfg_index, cfg_data                        to block
//
// one request at a time; the hole list is walked through a table with one
// read and one write port and a registered read.
// byte allocate: each hole visited takes a table read and a fit test.
// page allocate: each hole visited also takes a step for the alignment
// remainder (a mask, as the page size is a power of two).
// free: one table read per hole visited, then link-in and write-back steps.
// reset needs no clearing pass; a new request is taken while a result waits,
// and a waiting result holds the sequencer in its done state.
`default_nettype none
module first_fit_hole_allocator #(
  parameter int HOLE_SLOTS = ffha_pkg::HOLE_SLOTS_DEF,
  parameter int PAGE_BYTES = ffha_pkg::PAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] amount,
  input  wire logic [31:0] block_base,
  input  wire logic        align_16k,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] address,
  output logic      [1:0]  status,
  output logic      [31:0] free_bytes,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW     = $clog2(HOLE_SLOTS);
  localparam int IW     = $clog2(HOLE_SLOTS + 1);
  localparam int ALW    = ffha_pkg::ALIGN_W;
  localparam int NEED_W = 32 + ALW;
  localparam int DW     = 64 + IW;
  localparam logic [IW-1:0]  NIL       = IW'(HOLE_SLOTS);
  localparam logic [ALW-1:0] STD_ALIGN = ALW'(PAGE_BYTES);

  typedef struct packed {
    logic [31:0]   start;
    logic [31:0]   size;
    logic [IW-1:0] link;
  } hole_t;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_AWALK  = 4'd1;
  localparam logic [3:0] S_AMOD   = 4'd2;
  localparam logic [3:0] S_AFIT   = 4'd3;
  localparam logic [3:0] S_FPOP   = 4'd4;
  localparam logic [3:0] S_FPOPR  = 4'd5;
  localparam logic [3:0] S_FSTART = 4'd6;
  localparam logic [3:0] S_FFIRST = 4'd7;
  localparam logic [3:0] S_FWALK  = 4'd8;
  localparam logic [3:0] S_FSEC   = 4'd9;
  localparam logic [3:0] S_FRES   = 4'd10;
  localparam logic [3:0] S_WA     = 4'd11;
  localparam logic [3:0] S_WB     = 4'd12;
  localparam logic [3:0] S_WN     = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0]        state;
  logic [31:0]       pool_base;
  logic [31:0]       pool_length;
  logic [IW-1:0]     list_first;
  logic [IW-1:0]     spare_head;
  logic [IW-1:0]     fresh;
  logic [31:0]       free_total;

  logic [1:0]        kind_q;
  logic [31:0]       amount_q;
  logic [31:0]       base_q;
  logic              big_q;
  logic [NEED_W-1:0] need_r;
  logic [ALW-1:0]    gap_r;
  logic [31:0]       e_r;
  logic [31:0]       a_end;
  logic [31:0]       addr_r;
  logic [1:0]        status_r;

  hole_t             rec_a;
  hole_t             rec_b;
  hole_t             new_rec;
  logic [IW-1:0]     idx_a;
  logic [IW-1:0]     idx_b;
  logic [IW-1:0]     nw;
  logic              a_valid;
  logic              b_valid;
  logic              front_r;
  logic              wa;
  logic              wb;
  logic              wn;

  logic              accept;
  logic              full;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic [DW-1:0]     rd_data;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [DW-1:0]     wr_data;
  hole_t             dout;

  logic              rem_start;
  logic              rem_done;
  logic [ALW-1:0]    rem_val;
  logic [ALW-1:0]    align_cur;

  logic [NEED_W:0]   take;
  logic              fit;
  logic [31:0]       at;
  logic [31:0]       nstart;
  logic [31:0]       nsize;
  logic              credit;
  logic [31:0]       e_a;
  logic              adj1;
  logic              adj2;
  logic              adjp;
  logic              adjn;
  logic [IW-1:0]     nlink;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign full      = (spare_head == NIL) && (fresh == NIL);
  assign dout      = hole_t'(rd_data);
  assign align_cur = big_q ? ffha_pkg::BIG_ALIGN : STD_ALIGN;
  assign rem_start = (state == S_AWALK) && (kind_q == ffha_pkg::KIND_PAGES);

  // fit test for the hole under the allocation cursor
  assign take   = {1'b0, need_r} + (NEED_W + 1)'(gap_r);
  assign fit    = ((NEED_W + 1)'(rec_b.size) >= take);
  assign at     = rec_b.start + 32'(gap_r);
  assign nstart = rec_b.start + take[31:0];
  assign nsize  = rec_b.size - take[31:0];
  assign credit = a_valid && (a_end == at);

  // neighbour tests for a free
  assign e_a   = e_r + rec_a.size;
  assign adj1  = (e_r == rec_a.start);
  assign adj2  = b_valid && ((adj1 ? e_a : a_end) == rec_b.start);
  assign adjp  = (a_end == base_q);
  assign adjn  = b_valid && (e_r == rec_b.start);
  assign nlink = b_valid ? idx_b : NIL;

  // table read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = list_first;
    case (state)
      S_IDLE: begin
        if (accept && (kind == ffha_pkg::KIND_BYTES || kind == ffha_pkg::KIND_PAGES)
            && list_first != NIL) begin
          rd_en = 1'b1;
        end
      end
      S_AFIT: begin
        if (!fit && rec_b.link != NIL) begin
          rd_en   = 1'b1;
          rd_addr = rec_b.link;
        end
      end
      S_FPOP: begin
        if (spare_head != NIL) begin
          rd_en   = 1'b1;
          rd_addr = spare_head;
        end
      end
      S_FSTART: begin
        rd_en = (list_first != NIL);
      end
      S_FFIRST: begin
        rd_en   = (dout.link != NIL);
        rd_addr = dout.link;
      end
      S_FWALK: begin
        rd_en   = (base_q > dout.start) && (dout.link != NIL);
        rd_addr = dout.link;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // table write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_a;
    wr_data = rec_a;
    case (state)
      S_WA: begin
        wr_en = wa;
      end
      S_WB: begin
        wr_en   = wb;
        wr_addr = idx_b;
        wr_data = rec_b;
      end
      S_WN: begin
        wr_en   = wn;
        wr_addr = nw;
        wr_data = new_rec;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  ffha_ram #(
    .DEPTH(HOLE_SLOTS),
    .AW   (AW),
    .DW   (DW)
  ) u_ram (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr[AW-1:0]),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr[AW-1:0]),
    .wr_data(wr_data)
  );

  ffha_rem u_rem (
    .clk    (clk),
    .rst    (rst),
    .start  (rem_start),
    .value  (dout.start[ALW-1:0]),
    .divisor(align_cur),
    .done   (rem_done),
    .rem    (rem_val)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base   <= '0;
      pool_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ffha_pkg::CFG_POOL_BASE: pool_base   <= cfg_data;
        ffha_pkg::CFG_POOL_LEN:  pool_length <= cfg_data;
        default:                 pool_base   <= pool_base;
      endcase
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      list_first <= NIL;
      spare_head <= NIL;
      fresh      <= '0;
      free_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid  <= 1'b1;
        address    <= addr_r;
        status     <= status_r;
        free_bytes <= free_total;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q   <= kind;
            big_q    <= align_16k;
            addr_r   <= '0;
            status_r <= ffha_pkg::ST_OK;
            a_valid  <= 1'b0;
            idx_b    <= list_first;
            amount_q <= amount;
            base_q   <= block_base;
            need_r   <= (kind == ffha_pkg::KIND_PAGES) ?
                        NEED_W'(amount) * NEED_W'(STD_ALIGN) : NEED_W'(amount);
            case (kind)
              ffha_pkg::KIND_BYTES, ffha_pkg::KIND_PAGES: begin
                if (list_first == NIL) begin
                  status_r <= ffha_pkg::ST_NOMEM;
                  state    <= S_DONE;
                end else begin
                  state <= S_AWALK;
                end
              end
              ffha_pkg::KIND_FREE: begin
                if (amount == '0) begin
                  status_r <= ffha_pkg::ST_ZERO;
                  state    <= S_DONE;
                end else if (full) begin
                  status_r <= ffha_pkg::ST_FULL;
                  state    <= S_DONE;
                end else begin
                  state <= S_FPOP;
                end
              end
              default: begin
                // init: empty the table, then free the pool
                list_first <= NIL;
                spare_head <= NIL;
                fresh      <= '0;
                base_q     <= pool_base;
                amount_q   <= pool_length;
                if (pool_length == '0) begin
                  status_r <= ffha_pkg::ST_ZERO;
                  state    <= S_DONE;
                end else begin
                  state <= S_FPOP;
                end
              end
            endcase
          end
        end

        // allocation walk
        S_AWALK: begin
          rec_b <= dout;
          gap_r <= '0;
          state <= (kind_q == ffha_pkg::KIND_PAGES) ? S_AMOD : S_AFIT;
        end
        S_AMOD: begin
          if (rem_done) begin
            gap_r <= (rem_val == '0) ? '0 : align_cur - rem_val;
            state <= S_AFIT;
          end
        end
        S_AFIT: begin
          if (fit) begin
            addr_r     <= at;
            free_total <= free_total - need_r[31:0];
            rec_a.size <= rec_a.size + (credit ? 32'(gap_r) : 32'd0);
            rec_b.start <= nstart;
            rec_b.size  <= nsize;
            if (nsize == '0) begin
              if (a_valid) begin
                rec_a.link <= rec_b.link;
              end else begin
                list_first <= rec_b.link;
              end
              rec_b.link <= spare_head;
              spare_head <= idx_b;
            end
            wa    <= credit || (nsize == '0 && a_valid);
            wb    <= 1'b1;
            wn    <= 1'b0;
            state <= S_WA;
          end else if (rec_b.link == NIL) begin
            status_r <= ffha_pkg::ST_NOMEM;
            state    <= S_DONE;
          end else begin
            a_valid <= 1'b1;
            rec_a   <= rec_b;
            idx_a   <= idx_b;
            a_end   <= rec_b.start + rec_b.size;
            idx_b   <= rec_b.link;
            state   <= S_AWALK;
          end
        end

        // free: take a slot from the spare chain or the unused tail
        S_FPOP: begin
          free_total <= free_total + amount_q;
          e_r        <= base_q + amount_q;
          if (spare_head != NIL) begin
            nw    <= spare_head;
            state <= S_FPOPR;
          end else begin
            nw    <= fresh;
            fresh <= fresh + 1'b1;
            state <= S_FSTART;
          end
        end
        S_FPOPR: begin
          spare_head <= dout.link;
          state      <= S_FSTART;
        end
        S_FSTART: begin
          if (list_first == NIL) begin
            new_rec    <= '{start: base_q, size: amount_q, link: NIL};
            list_first <= nw;
            wa         <= 1'b0;
            wb         <= 1'b0;
            wn         <= 1'b1;
            state      <= S_WA;
          end else begin
            idx_a <= list_first;
            state <= S_FFIRST;
          end
        end
        S_FFIRST: begin
          rec_a   <= dout;
          a_end   <= dout.start + dout.size;
          front_r <= (base_q <= dout.start);
          if (dout.link != NIL) begin
            idx_b <= dout.link;
            state <= (base_q <= dout.start) ? S_FSEC : S_FWALK;
          end else begin
            b_valid <= 1'b0;
            state   <= S_FRES;
          end
        end
        S_FSEC: begin
          rec_b   <= dout;
          b_valid <= 1'b1;
          state   <= S_FRES;
        end
        S_FWALK: begin
          if (base_q > dout.start) begin
            rec_a <= dout;
            idx_a <= idx_b;
            a_end <= dout.start + dout.size;
            if (dout.link != NIL) begin
              idx_b <= dout.link;
            end else begin
              b_valid <= 1'b0;
              state   <= S_FRES;
            end
          end else begin
            rec_b   <= dout;
            b_valid <= 1'b1;
            state   <= S_FRES;
          end
        end

        // free: link in and merge with neighbours
        S_FRES: begin
          wn    <= 1'b1;
          state <= S_WA;
          if (front_r) begin
            list_first <= nw;
            if (adj1) begin
              new_rec <= '{start: base_q,
                           size: amount_q + rec_a.size + (adj2 ? rec_b.size : 32'd0),
                           link: adj2 ? rec_b.link : rec_a.link};
              rec_a.link <= spare_head;
              wa         <= 1'b1;
              if (adj2) begin
                rec_b.link <= idx_a;
                spare_head <= idx_b;
                wb         <= 1'b1;
              end else begin
                spare_head <= idx_a;
                wb         <= 1'b0;
              end
            end else begin
              new_rec <= '{start: base_q, size: amount_q, link: idx_a};
              if (adj2) begin
                rec_a.size <= rec_a.size + rec_b.size;
                rec_a.link <= rec_b.link;
                rec_b.link <= spare_head;
                spare_head <= idx_b;
                wa         <= 1'b1;
                wb         <= 1'b1;
              end else begin
                wa <= 1'b0;
                wb <= 1'b0;
              end
            end
          end else begin
            wa <= 1'b1;
            if (adjp) begin
              rec_a.size   <= rec_a.size + amount_q + (adjn ? rec_b.size : 32'd0);
              rec_a.link   <= adjn ? rec_b.link : nlink;
              new_rec.link <= spare_head;
              if (adjn) begin
                rec_b.link <= nw;
                spare_head <= idx_b;
                wb         <= 1'b1;
              end else begin
                spare_head <= nw;
                wb         <= 1'b0;
              end
            end else begin
              rec_a.link <= nw;
              new_rec    <= '{start: base_q,
                              size: amount_q + (adjn ? rec_b.size : 32'd0),
                              link: adjn ? rec_b.link : nlink};
              if (adjn) begin
                rec_b.link <= spare_head;
                spare_head <= idx_b;
                wb         <= 1'b1;
              end else begin
                wb <= 1'b0;
              end
            end
          end
        end

        // write-back sequence
        S_WA: state <= S_WB;
        S_WB: state <= S_WN;
        S_WN: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // reads and writes of the table never share a cycle
  assert property (@(posedge clk) disable iff (rst) wr_en |-> !rd_en)
    else $error("table read and write in the same cycle");

  // the unused tail pointer never passes the table depth
  assert property (@(posedge clk) disable iff (rst) fresh <= NIL)
    else $error("fresh slot pointer out of range");

  // a finished request always reaches the output register
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> out_valid)
    else $error("finished result not presented");

  // failures report address zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ffha_pkg::ST_OK) |-> (address == '0))
    else $error("non-zero address on failure");

  // zero-length free finishes at once
  assert property (@(posedge clk) disable iff (rst)
    (accept && kind == ffha_pkg::KIND_FREE && amount == '0) |=> (state == S_DONE))
    else $error("zero-length free did not complete directly");
`endif

endmodule
`default_nettype wire
